// ===== sv/hrst_pkg.sv =====
// Package with the item types, phase codes and fixed sizes of the HTTP request tokenizer.
`default_nettype none
package hrst_pkg;

  // One input item.
  typedef struct packed {
    logic       req_type;
    logic [1:0] conn_id;
    logic [7:0] data_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  out_conn;
    logic [3:0]  byte_class;
    logic [7:0]  out_byte;
    logic        kept;
    logic [8:0]  position;
    logic [3:0]  entry_index;
    logic        entry_done;
    logic [31:0] length_value;
    logic [1:0]  status;
  } out_item_t;

  // Byte kinds found by the front end.
  typedef enum logic [3:0] {
    BK_OTHER = 4'd0,
    BK_SPACE = 4'd1,
    BK_QMARK = 4'd2,
    BK_AMP   = 4'd3,
    BK_EQ    = 4'd4,
    BK_COLON = 4'd5,
    BK_CR    = 4'd6,
    BK_LF    = 4'd7,
    BK_DIGIT = 4'd8
  } byte_kind_t;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    logic       req_type;
    logic [1:0] conn_id;
    logic [7:0] data_byte;
    logic [7:0] lower_byte;
    byte_kind_t kind;
  } cls_item_t;

  // Parser phases, one-hot.
  typedef enum logic [10:0] {
    PH_METHOD  = 11'b00000000001,
    PH_PATH    = 11'b00000000010,
    PH_QUERY   = 11'b00000000100,
    PH_VERSION = 11'b00000001000,
    PH_LF      = 11'b00000010000,
    PH_HKEY    = 11'b00000100000,
    PH_HVAL    = 11'b00001000000,
    PH_BODY_LF = 11'b00010000000,
    PH_BODY    = 11'b00100000000,
    PH_DONE    = 11'b01000000000,
    PH_ERR     = 11'b10000000000
  } phase_t;

  // Byte classes.
  localparam logic [3:0] CLS_NONE    = 4'd0;
  localparam logic [3:0] CLS_METHOD  = 4'd1;
  localparam logic [3:0] CLS_PATH    = 4'd2;
  localparam logic [3:0] CLS_QKEY    = 4'd3;
  localparam logic [3:0] CLS_QVAL    = 4'd4;
  localparam logic [3:0] CLS_VERSION = 4'd5;
  localparam logic [3:0] CLS_HKEY    = 4'd6;
  localparam logic [3:0] CLS_HVAL    = 4'd7;
  localparam logic [3:0] CLS_BODY    = 4'd8;

  // Status codes.
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Fixed capacities.
  localparam int METHOD_CAP  = 8;
  localparam int QKEY_CAP    = 32;
  localparam int QVAL_CAP    = 64;
  localparam int QPAIR_MAX   = 8;
  localparam int CL_NAME_LEN = 14;

  // Lower-case letters of the length header name.
  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        4'd0: c = "c";
        4'd1: c = "o";
        4'd2: c = "n";
        4'd3: c = "t";
        4'd4: c = "e";
        4'd5: c = "n";
        4'd6: c = "t";
        4'd7: c = "-";
        4'd8: c = "l";
        4'd9: c = "e";
        4'd10: c = "n";
        4'd11: c = "g";
        4'd12: c = "t";
        4'd13: c = "h";
        default: c = 8'd0;
      endcase
      return c;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/hrst_front.sv =====
// Front end: accepts items, classifies the byte and registers the result.
`default_nettype none
module hrst_front import hrst_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  in_item,
  input  wire logic      in_valid,
  output logic           in_ready,
  output cls_item_t      cls_item,
  output logic           cls_valid,
  input  wire logic      cls_ready
);

  cls_item_t  cls_next;
  byte_kind_t kind;

  // Byte classification.
  always_comb begin
    case (in_item.data_byte)
      8'h20: kind = BK_SPACE;
      8'h3F: kind = BK_QMARK;
      8'h26: kind = BK_AMP;
      8'h3D: kind = BK_EQ;
      8'h3A: kind = BK_COLON;
      8'h0D: kind = BK_CR;
      8'h0A: kind = BK_LF;
      default: kind = (in_item.data_byte inside {[8'h30:8'h39]}) ? BK_DIGIT : BK_OTHER;
    endcase
    cls_next.req_type   = in_item.req_type;
    cls_next.conn_id    = in_item.conn_id;
    cls_next.data_byte  = in_item.data_byte;
    cls_next.lower_byte = (in_item.data_byte inside {[8'h41:8'h5A]}) ?
                          in_item.data_byte + 8'd32 : in_item.data_byte;
    cls_next.kind       = kind;
  end

  assign in_ready = !cls_valid || cls_ready;

  // Pipeline register toward the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (in_ready) begin
      cls_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cls_item <= cls_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hrst_queue.sv =====
// Short queue of classified items between the front and back ends.
`default_nettype none
module hrst_queue import hrst_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cls_item_t wr_item,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  output cls_item_t      rd_item,
  output logic           rd_valid,
  input  wire logic      rd_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cls_item_t      slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_wr;
  logic           do_rd;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hrst_back.sv =====
// Back end: per-connection parser state update and result register.
`default_nettype none
module hrst_back import hrst_pkg::*; #(
  parameter int CONNECTIONS = 4,
  parameter int PATH_LEN    = 64,
  parameter int QUERY_LEN   = 64,
  parameter int HEADERS     = 8,
  parameter int FIELD_LEN   = 32,
  parameter int BODY_BYTES  = 512
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cls_item_t cls_item,
  input  wire logic      cls_valid,
  output logic           cls_ready,
  output out_item_t      res_item,
  output logic           res_valid,
  input  wire logic      res_ready
);

  localparam int PCW = $clog2(PATH_LEN);
  localparam int QBW = $clog2(QUERY_LEN);
  localparam int HW  = $clog2(HEADERS + 1);
  localparam int BSW = $clog2(BODY_BYTES + 1);

  // Per-connection state, each entry used at the item's connection.
  phase_t         phase         [CONNECTIONS];
  logic [5:0]     token_pos     [CONNECTIONS];
  logic [PCW-1:0] path_count    [CONNECTIONS];
  logic [QBW-1:0] query_bytes   [CONNECTIONS];
  logic [HW-1:0]  header_total  [CONNECTIONS];
  logic [3:0]     pair_total    [CONNECTIONS];
  logic [4:0]     pair_key_pos  [CONNECTIONS];
  logic [5:0]     pair_val_pos  [CONNECTIONS];
  logic           pair_in_value [CONNECTIONS];
  logic [31:0]    body_length   [CONNECTIONS];
  logic [31:0]    body_seen     [CONNECTIONS];
  logic [BSW-1:0] body_stored   [CONNECTIONS];
  logic           name_matches  [CONNECTIONS];
  logic           digits_open   [CONNECTIONS];
  logic [31:0]    digit_accum   [CONNECTIONS];

  phase_t         ph_n;
  logic [5:0]     tp_n;
  logic [PCW-1:0] pc_n;
  logic [QBW-1:0] qb_n;
  logic [HW-1:0]  ht_n;
  logic [3:0]     pt_n;
  logic [4:0]     kp_n;
  logic [5:0]     vp_n;
  logic           iv_n;
  logic [31:0]    bl_n;
  logic [31:0]    bs_n;
  logic [BSW-1:0] bst_n;
  logic           nm_n;
  logic           do_n;
  logic [31:0]    da_n;
  out_item_t      res_next;
  logic           in_range;
  logic           fire;
  logic [1:0]     c;
  logic [7:0]     b;
  logic [35:0]    acc_x10;
  logic [35:0]    acc_sum;

  assign c         = cls_item.conn_id;
  assign b         = cls_item.data_byte;
  assign in_range  = (32'(c) < 32'(CONNECTIONS));
  assign cls_ready = !res_valid || res_ready;
  assign fire      = cls_valid && cls_ready;

  // Decimal accumulate with saturation.
  assign acc_x10 = {4'd0, digit_accum[c]} * 36'd10;
  assign acc_sum = acc_x10 + {28'd0, b - 8'h30};

  // State update for the item's connection.
  always_comb begin
    ph_n = phase[c];        tp_n = token_pos[c];     pc_n = path_count[c];
    qb_n = query_bytes[c];  ht_n = header_total[c];  pt_n = pair_total[c];
    kp_n = pair_key_pos[c]; vp_n = pair_val_pos[c];  iv_n = pair_in_value[c];
    bl_n = body_length[c];  bs_n = body_seen[c];     bst_n = body_stored[c];
    nm_n = name_matches[c]; do_n = digits_open[c];   da_n = digit_accum[c];
    res_next = '0;
    res_next.out_conn = c;
    if (in_range) begin
      if (cls_item.req_type) begin
        ph_n = PH_METHOD; tp_n = '0; pc_n = '0; qb_n = '0; ht_n = '0; pt_n = '0;
        kp_n = '0; vp_n = '0; iv_n = 1'b0; bl_n = '0; bs_n = '0; bst_n = '0;
        nm_n = 1'b1; do_n = 1'b1; da_n = '0;
      end else begin
        res_next.out_byte = b;
        case (phase[c])
          PH_METHOD: begin
            if (cls_item.kind == BK_SPACE) begin
              ph_n = PH_PATH;
              tp_n = '0;
            end else begin
              res_next.byte_class = CLS_METHOD;
              if (32'(token_pos[c]) < METHOD_CAP - 1) begin
                res_next.kept = 1'b1;
                res_next.position = 9'(token_pos[c]);
                tp_n = token_pos[c] + 6'd1;
              end else begin
                ph_n = PH_ERR;
              end
            end
          end
          PH_PATH: begin
            if (cls_item.kind == BK_SPACE) begin
              ph_n = PH_VERSION;
            end else if (cls_item.kind == BK_QMARK) begin
              ph_n = PH_QUERY;
            end else begin
              res_next.byte_class = CLS_PATH;
              if (32'(path_count[c]) < PATH_LEN - 1) begin
                res_next.kept = 1'b1;
                res_next.position = 9'(path_count[c]);
                pc_n = path_count[c] + 1'b1;
              end else begin
                ph_n = PH_ERR;
              end
            end
          end
          PH_QUERY: begin
            if (cls_item.kind == BK_SPACE) begin
              if (32'(pair_total[c]) < QPAIR_MAX && pair_key_pos[c] != '0) begin
                res_next.entry_index = pair_total[c];
                res_next.entry_done = 1'b1;
                pt_n = pair_total[c] + 4'd1;
              end
              ph_n = PH_VERSION;
            end else begin
              res_next.byte_class = pair_in_value[c] ? CLS_QVAL : CLS_QKEY;
              if (32'(query_bytes[c]) < QUERY_LEN - 1) begin
                qb_n = query_bytes[c] + 1'b1;
                if (32'(pair_total[c]) < QPAIR_MAX) begin
                  res_next.entry_index = pair_total[c];
                  if (cls_item.kind == BK_AMP) begin
                    res_next.byte_class = CLS_NONE;
                    if (pair_key_pos[c] != '0) begin
                      res_next.entry_done = 1'b1;
                      pt_n = pair_total[c] + 4'd1;
                    end
                    kp_n = '0;
                    vp_n = '0;
                    iv_n = 1'b0;
                  end else if (cls_item.kind == BK_EQ && !pair_in_value[c]) begin
                    res_next.byte_class = CLS_NONE;
                    iv_n = 1'b1;
                  end else if (!pair_in_value[c]) begin
                    if (32'(pair_key_pos[c]) < QKEY_CAP - 1) begin
                      res_next.kept = 1'b1;
                      res_next.position = 9'(pair_key_pos[c]);
                      kp_n = pair_key_pos[c] + 5'd1;
                    end
                  end else if (32'(pair_val_pos[c]) < QVAL_CAP - 1) begin
                    res_next.kept = 1'b1;
                    res_next.position = 9'(pair_val_pos[c]);
                    vp_n = pair_val_pos[c] + 6'd1;
                  end
                end
              end
            end
          end
          PH_VERSION: begin
            if (cls_item.kind == BK_CR) begin
              ph_n = PH_LF;
            end else begin
              res_next.byte_class = CLS_VERSION;
            end
          end
          PH_LF: begin
            if (cls_item.kind == BK_LF) begin
              ph_n = PH_HKEY;
              tp_n = '0;
              nm_n = 1'b1;
              do_n = 1'b1;
              da_n = '0;
            end else begin
              ph_n = PH_ERR;
            end
          end
          PH_HKEY: begin
            if (cls_item.kind == BK_CR) begin
              ph_n = PH_BODY_LF;
            end else if (cls_item.kind == BK_COLON) begin
              if (32'(token_pos[c]) != CL_NAME_LEN) begin
                nm_n = 1'b0;
              end
              ph_n = PH_HVAL;
              tp_n = '0;
            end else begin
              res_next.byte_class = CLS_HKEY;
              if (32'(header_total[c]) < HEADERS) begin
                res_next.entry_index = 4'(header_total[c]);
                if (32'(token_pos[c]) < FIELD_LEN - 1) begin
                  res_next.kept = 1'b1;
                  res_next.position = 9'(token_pos[c]);
                  if (32'(token_pos[c]) >= CL_NAME_LEN ||
                      cls_item.lower_byte != cl_char(token_pos[c][3:0])) begin
                    nm_n = 1'b0;
                  end
                  tp_n = token_pos[c] + 6'd1;
                end
              end
            end
          end
          PH_HVAL: begin
            if (cls_item.kind == BK_SPACE && token_pos[c] == '0) begin
              ph_n = PH_HVAL;
            end else if (cls_item.kind == BK_CR) begin
              if (32'(header_total[c]) < HEADERS) begin
                if (name_matches[c]) begin
                  bl_n = digit_accum[c];
                end
                res_next.entry_index = 4'(header_total[c]);
                res_next.entry_done = 1'b1;
                ht_n = header_total[c] + 1'b1;
              end
              ph_n = PH_LF;
            end else begin
              res_next.byte_class = CLS_HVAL;
              if (32'(header_total[c]) < HEADERS) begin
                res_next.entry_index = 4'(header_total[c]);
                if (32'(token_pos[c]) < FIELD_LEN - 1) begin
                  res_next.kept = 1'b1;
                  res_next.position = 9'(token_pos[c]);
                  tp_n = token_pos[c] + 6'd1;
                  if (digits_open[c]) begin
                    if (cls_item.kind == BK_DIGIT) begin
                      da_n = (acc_sum[35:32] != '0) ? 32'hFFFF_FFFF : acc_sum[31:0];
                    end else begin
                      do_n = 1'b0;
                    end
                  end
                end
              end
            end
          end
          PH_BODY_LF: begin
            if (cls_item.kind == BK_LF) begin
              ph_n = (body_length[c] == '0) ? PH_DONE : PH_BODY;
            end else begin
              ph_n = PH_ERR;
            end
          end
          PH_BODY: begin
            res_next.byte_class = CLS_BODY;
            if (32'(body_stored[c]) < BODY_BYTES) begin
              res_next.kept = 1'b1;
              res_next.position = 9'(body_stored[c]);
              bst_n = body_stored[c] + 1'b1;
            end
            bs_n = body_seen[c] + 32'd1;
            if (bs_n >= body_length[c]) begin
              ph_n = PH_DONE;
            end
          end
          default: begin
            res_next.byte_class = CLS_NONE;
          end
        endcase
      end
      res_next.length_value = bl_n;
      if (ph_n == PH_DONE) begin
        res_next.status = ST_DONE;
      end else if (ph_n == PH_ERR) begin
        res_next.status = ST_ERROR;
      end else begin
        res_next.status = ST_BUSY;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONNECTIONS; i++) begin
        phase[i] <= PH_METHOD;       token_pos[i] <= '0;     path_count[i] <= '0;
        query_bytes[i] <= '0;        header_total[i] <= '0;  pair_total[i] <= '0;
        pair_key_pos[i] <= '0;       pair_val_pos[i] <= '0;  pair_in_value[i] <= 1'b0;
        body_length[i] <= '0;        body_seen[i] <= '0;     body_stored[i] <= '0;
        name_matches[i] <= 1'b1;     digits_open[i] <= 1'b1; digit_accum[i] <= '0;
      end
    end else if (fire && in_range) begin
      phase[c] <= ph_n;          token_pos[c] <= tp_n;     path_count[c] <= pc_n;
      query_bytes[c] <= qb_n;    header_total[c] <= ht_n;  pair_total[c] <= pt_n;
      pair_key_pos[c] <= kp_n;   pair_val_pos[c] <= vp_n;  pair_in_value[c] <= iv_n;
      body_length[c] <= bl_n;    body_seen[c] <= bs_n;     body_stored[c] <= bst_n;
      name_matches[c] <= nm_n;   digits_open[c] <= do_n;   digit_accum[c] <= da_n;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cls_ready) begin
      res_valid <= cls_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_item <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/http_request_stream_tokenizer.sv =====
// Top level of the HTTP/1.1 request tokenizer.
//
// Usage: input items (a start marker or one request byte, with a connection
// number) are pushed while full is low. Each item gives exactly one result
// item, available while empty is low and taken with pop.
// A start item clears that connection's parser state. Each byte is tagged as
// method, path, query, version, header or body, with its position, kept flag,
// entry number, current content length and request status.
// Path: an accepted item is held in the front register, then in a queue
// slot, and then its result in the result register; the queue output is read
// straight from its slot.
// Throughput: one item per cycle while pop keeps up, with the state update in
// the back end combinational.
// When pop stays low, results hold and the queue fills; full rises once the
// queue and both registers are occupied, and nothing is lost.
// Reset (rst, synchronous) empties the pipeline and returns every
// connection to the method phase with all counts cleared.
`default_nettype none
module http_request_stream_tokenizer import hrst_pkg::*; #(
  parameter int CONNECTIONS = 4,
  parameter int PATH_LEN    = 64,
  parameter int QUERY_LEN   = 64,
  parameter int HEADERS     = 8,
  parameter int FIELD_LEN   = 32,
  parameter int BODY_BYTES  = 512
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t in_item,
  input  wire logic     push,
  output logic          full,
  output out_item_t     out_item,
  output logic          empty,
  input  wire logic     pop
);

  cls_item_t f_item;
  logic      f_valid;
  logic      f_ready;
  cls_item_t q_item;
  logic      q_valid;
  logic      q_ready;
  logic      in_ready;
  logic      res_valid;

  assign full  = !in_ready;
  assign empty = !res_valid;

  hrst_front u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .in_valid(push), .in_ready(in_ready),
    .cls_item(f_item), .cls_valid(f_valid), .cls_ready(f_ready)
  );

  hrst_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst(rst), .wr_item(f_item), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_item(q_item), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  hrst_back #(
    .CONNECTIONS(CONNECTIONS), .PATH_LEN(PATH_LEN), .QUERY_LEN(QUERY_LEN),
    .HEADERS(HEADERS), .FIELD_LEN(FIELD_LEN), .BODY_BYTES(BODY_BYTES)
  ) u_back (
    .clk(clk), .rst(rst), .cls_item(q_item), .cls_valid(q_valid), .cls_ready(q_ready),
    .res_item(out_item), .res_valid(res_valid), .res_ready(pop)
  );

endmodule
`default_nettype wire

// ===== sim/tb_http_request_stream_tokenizer.sv =====
// Self-checking testbench for the HTTP/1.1 request stream tokenizer.
`default_nettype none
module tb_http_request_stream_tokenizer import hrst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CONNS     = 4;
  localparam int PATH_CAP  = 64;
  localparam int QUERY_CAP = 64;
  localparam int HDR_MAX   = 8;
  localparam int FLD_CAP   = 32;
  localparam int BODY_CAP  = 512;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_ITEMS   = 1100;

  // Local phase codes of the predictor.
  typedef enum int {
    P_METHOD, P_PATH, P_QUERY, P_VERSION, P_LF, P_HKEY, P_HVAL,
    P_BODY_LF, P_BODY, P_DONE, P_ERR
  } pphase_t;

  logic      clk;
  logic      rst;
  in_item_t  in_item;
  logic      push;
  logic      full;
  out_item_t out_item;
  logic      empty;
  logic      pop;

  http_request_stream_tokenizer dut (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .out_item(out_item), .empty(empty), .pop(pop)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Per-connection parser state of the predictor.
  pphase_t     ph      [CONNS];
  int unsigned tok     [CONNS];
  int unsigned npath   [CONNS];
  int unsigned nquery  [CONNS];
  int unsigned nhdr    [CONNS];
  int unsigned npair   [CONNS];
  int unsigned kpos    [CONNS];
  int unsigned vpos    [CONNS];
  bit          in_val  [CONNS];
  logic [31:0] blen    [CONNS];
  logic [31:0] bseen   [CONNS];
  int unsigned bstored [CONNS];
  bit          cl_hit  [CONNS];
  bit          dig_open[CONNS];
  logic [31:0] dig_acc [CONNS];

  out_item_t   expected_results[$];
  int          errors;
  int          cycles;
  int          n_pushed, n_popped, n_done, n_err;

  // Stimulus table: item and, where typed in, the plain expected class/status.
  typedef struct {
    in_item_t  item;
    bit        has_exp;
    logic [3:0] exp_cls;
    logic [1:0] exp_st;
  } stim_row_t;
  stim_row_t directed_rows[$];

  function automatic void clear_conn(int c);
    ph[c] = P_METHOD; tok[c] = 0; npath[c] = 0; nquery[c] = 0; nhdr[c] = 0;
    npair[c] = 0; kpos[c] = 0; vpos[c] = 0; in_val[c] = 0; blen[c] = 0;
    bseen[c] = 0; bstored[c] = 0; cl_hit[c] = 1; dig_open[c] = 1; dig_acc[c] = 0;
  endfunction

  function automatic logic [7:0] cl_lower_at(int i);
    string s;
    s = "content-length";
    return s[i];
  endfunction

  // Predicts the single result of one accepted item and advances the state.
  function automatic out_item_t tokenize_byte(in_item_t it);
    out_item_t r;
    int c;
    logic [7:0] b, lo;
    logic [31:0] d;
    r = '0;
    c = it.conn_id;
    b = it.data_byte;
    r.out_conn = it.conn_id;
    if (it.req_type) begin
      clear_conn(c);
    end else begin
      r.out_byte = b;
      case (ph[c])
        P_METHOD: begin
          if (b == " ") begin
            ph[c] = P_PATH; tok[c] = 0;
          end else begin
            r.byte_class = CLS_METHOD;
            if (tok[c] < METHOD_CAP - 1) begin
              r.kept = 1; r.position = 9'(tok[c]); tok[c]++;
            end else ph[c] = P_ERR;
          end
        end
        P_PATH: begin
          if (b == " ") ph[c] = P_VERSION;
          else if (b == "?") ph[c] = P_QUERY;
          else begin
            r.byte_class = CLS_PATH;
            if (npath[c] < PATH_CAP - 1) begin
              r.kept = 1; r.position = 9'(npath[c]); npath[c]++;
            end else ph[c] = P_ERR;
          end
        end
        P_QUERY: begin
          if (b == " ") begin
            if (npair[c] < QPAIR_MAX && kpos[c] > 0) begin
              r.entry_index = 4'(npair[c]); npair[c]++; r.entry_done = 1;
            end
            ph[c] = P_VERSION;
          end else begin
            r.byte_class = in_val[c] ? CLS_QVAL : CLS_QKEY;
            if (nquery[c] < QUERY_CAP - 1) begin
              nquery[c]++;
              if (npair[c] < QPAIR_MAX) begin
                r.entry_index = 4'(npair[c]);
                if (b == "&") begin
                  r.byte_class = CLS_NONE;
                  if (kpos[c] > 0) begin
                    r.entry_done = 1; npair[c]++;
                  end
                  kpos[c] = 0; vpos[c] = 0; in_val[c] = 0;
                end else if (b == "=" && !in_val[c]) begin
                  r.byte_class = CLS_NONE; in_val[c] = 1;
                end else if (!in_val[c]) begin
                  if (kpos[c] < QKEY_CAP - 1) begin
                    r.kept = 1; r.position = 9'(kpos[c]); kpos[c]++;
                  end
                end else if (vpos[c] < QVAL_CAP - 1) begin
                  r.kept = 1; r.position = 9'(vpos[c]); vpos[c]++;
                end
              end
            end
          end
        end
        P_VERSION: begin
          if (b == 8'h0d) ph[c] = P_LF;
          else r.byte_class = CLS_VERSION;
        end
        P_LF: begin
          if (b == 8'h0a) begin
            ph[c] = P_HKEY; tok[c] = 0; cl_hit[c] = 1; dig_open[c] = 1; dig_acc[c] = 0;
          end else ph[c] = P_ERR;
        end
        P_HKEY: begin
          if (b == 8'h0d) ph[c] = P_BODY_LF;
          else if (b == ":") begin
            if (tok[c] != CL_NAME_LEN) cl_hit[c] = 0;
            ph[c] = P_HVAL; tok[c] = 0;
          end else begin
            r.byte_class = CLS_HKEY;
            if (nhdr[c] < HDR_MAX) begin
              r.entry_index = 4'(nhdr[c]);
              if (tok[c] < FLD_CAP - 1) begin
                lo = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                r.kept = 1; r.position = 9'(tok[c]);
                if (tok[c] >= CL_NAME_LEN || lo != cl_lower_at(tok[c])) cl_hit[c] = 0;
                tok[c]++;
              end
            end
          end
        end
        P_HVAL: begin
          if (b == " " && tok[c] == 0) begin
            // Leading spaces are delimiters.
          end else if (b == 8'h0d) begin
            if (nhdr[c] < HDR_MAX) begin
              if (cl_hit[c]) blen[c] = dig_acc[c];
              r.entry_index = 4'(nhdr[c]); nhdr[c]++; r.entry_done = 1;
            end
            ph[c] = P_LF;
          end else begin
            r.byte_class = CLS_HVAL;
            if (nhdr[c] < HDR_MAX) begin
              r.entry_index = 4'(nhdr[c]);
              if (tok[c] < FLD_CAP - 1) begin
                r.kept = 1; r.position = 9'(tok[c]); tok[c]++;
                if (dig_open[c]) begin
                  if (b >= "0" && b <= "9") begin
                    d = {24'd0, b - 8'h30};
                    if (dig_acc[c] > (32'hFFFF_FFFF - d) / 32'd10) dig_acc[c] = 32'hFFFF_FFFF;
                    else dig_acc[c] = dig_acc[c] * 32'd10 + d;
                  end else dig_open[c] = 0;
                end
              end
            end
          end
        end
        P_BODY_LF: begin
          if (b == 8'h0a) ph[c] = (blen[c] == 0) ? P_DONE : P_BODY;
          else ph[c] = P_ERR;
        end
        P_BODY: begin
          r.byte_class = CLS_BODY;
          if (bstored[c] < BODY_CAP) begin
            r.kept = 1; r.position = 9'(bstored[c]); bstored[c]++;
          end
          bseen[c]++;
          if (bseen[c] >= blen[c]) ph[c] = P_DONE;
        end
        default: ;
      endcase
    end
    r.length_value = blen[c];
    if (ph[c] == P_DONE) r.status = ST_DONE;
    else if (ph[c] == P_ERR) r.status = ST_ERROR;
    else r.status = ST_BUSY;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_popped);
    errors++;
  endtask

  // Pending direct checks from the directed table, aligned with results.
  bit          typed_q_has[$];
  logic [3:0]  typed_q_cls[$];
  logic [1:0]  typed_q_st[$];

  // Result side: random pop, compare with the oldest expectation.
  always @(posedge clk) begin
    out_item_t w;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        w = expected_results.pop_front();
        if (out_item.out_conn != w.out_conn) report_mismatch("out_conn", out_item.out_conn, w.out_conn);
        if (out_item.byte_class != w.byte_class) report_mismatch("byte_class", out_item.byte_class, w.byte_class);
        if (out_item.out_byte != w.out_byte) report_mismatch("out_byte", out_item.out_byte, w.out_byte);
        if (out_item.kept != w.kept) report_mismatch("kept", out_item.kept, w.kept);
        if (out_item.position != w.position) report_mismatch("position", out_item.position, w.position);
        if (out_item.entry_index != w.entry_index)
          report_mismatch("entry_index", out_item.entry_index, w.entry_index);
        if (out_item.entry_done != w.entry_done)
          report_mismatch("entry_done", out_item.entry_done, w.entry_done);
        if (out_item.length_value != w.length_value)
          report_mismatch("length_value", out_item.length_value, w.length_value);
        if (out_item.status != w.status) report_mismatch("status", out_item.status, w.status);
        if (typed_q_has.size() > 0) begin
          if (typed_q_has.pop_front()) begin
            if (out_item.byte_class != typed_q_cls[0]) report_mismatch("typed class", out_item.byte_class, typed_q_cls[0]);
            if (out_item.status != typed_q_st[0]) report_mismatch("typed status", out_item.status, typed_q_st[0]);
          end
          void'(typed_q_cls.pop_front());
          void'(typed_q_st.pop_front());
        end
        if (w.status == ST_DONE) n_done++;
        if (w.status == ST_ERROR) n_err++;
      end
      n_popped++;
    end
  end

  // Receiver stalls: mostly short gaps, some long, with quiet stretches.
  initial begin
    int gap;
    pop = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < 30) begin
        pop <= 1'b0;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(negedge clk);
    end
  end

  // Cycle counter with a timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drives one item at the falling edge and holds it until accepted.
  // The push line stays high afterward so items can follow back to back.
  task automatic send_item(in_item_t it, bit has_exp, logic [3:0] ecls, logic [1:0] est);
    int gap;
    if ($urandom_range(0, 99) < 20) begin
      push <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_results.push_back(tokenize_byte(it));
    typed_q_has.push_back(has_exp);
    typed_q_cls.push_back(ecls);
    typed_q_st.push_back(est);
    n_pushed++;
    @(negedge clk);
  endtask

  // Drops push after the last item of a burst.
  task automatic hold_input();
    push <= 1'b0;
  endtask

  task automatic send_byte(int c, logic [7:0] b);
    in_item_t it;
    it.req_type = 1'b0; it.conn_id = 2'(c); it.data_byte = b;
    send_item(it, 0, CLS_NONE, ST_BUSY);
  endtask

  task automatic send_start(int c);
    in_item_t it;
    it.req_type = 1'b1; it.conn_id = 2'(c); it.data_byte = 8'($urandom_range(0, 255));
    send_item(it, 0, CLS_NONE, ST_BUSY);
  endtask

  task automatic send_text(int c, string s);
    for (int i = 0; i < s.len(); i++) send_byte(c, s[i]);
  endtask

  function automatic void add_row(bit rq, int c, logic [7:0] b, bit he, logic [3:0] cl,
                                  logic [1:0] st);
    stim_row_t r;
    r.item.req_type = rq; r.item.conn_id = 2'(c); r.item.data_byte = b;
    r.has_exp = he; r.exp_cls = cl; r.exp_st = st;
    directed_rows.push_back(r);
  endfunction

  function automatic string rand_token(int maxlen, bit digits);
    string s;
    int n;
    byte ch;
    s = "";
    n = $urandom_range(0, maxlen);
    for (int i = 0; i < n; i++) begin
      ch = digits ? 8'(48 + $urandom_range(0, 9)) : 8'(97 + $urandom_range(0, 25));
      s = {s, $sformatf("%c", ch)};
    end
    return s;
  endfunction

  // Sends one well-formed request with random content, maybe broken.
  task automatic send_request(int c);
    string q, body;
    int np, nh, bl, mode;
    send_start(c);
    send_text(c, $urandom_range(0, 9) == 0 ? "VERYLONGMETHOD" : "GET");
    send_byte(c, " ");
    send_text(c, {"/", rand_token($urandom_range(0, 9) == 0 ? 70 : 8, 0)});
    if ($urandom_range(0, 1)) begin
      send_byte(c, "?");
      np = $urandom_range(0, 10);
      for (int i = 0; i < np; i++) begin
        q = rand_token(4, 0);
        if ($urandom_range(0, 3) != 0) q = {q, "=", rand_token(5, 0)};
        if ($urandom_range(0, 7) == 0) q = {q, "=x"};
        send_text(c, q);
        if (i != np - 1) send_byte(c, "&");
      end
    end
    send_text(c, " HTTP/1.1\r");
    if ($urandom_range(0, 19) == 0) send_byte(c, "x");
    send_byte(c, 8'h0a);
    nh = $urandom_range(0, 10);
    bl = 0;
    for (int i = 0; i < nh; i++) begin
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        bl = $urandom_range(0, 6);
        send_text(c, $urandom_range(0, 1) ? "content-LENGTH: " : "Content-Length:");
        send_text(c, $sformatf("%0d", bl));
      end else if (mode == 1) begin
        send_text(c, "Content-Length: 99999999999");
      end else begin
        send_text(c, {rand_token(6, 0), ": ", rand_token(6, $urandom_range(0, 1))});
      end
      send_byte(c, 8'h0d);
      send_byte(c, 8'h0a);
    end
    send_byte(c, 8'h0d);
    send_byte(c, 8'h0a);
    body = rand_token(8, 0);
    send_text(c, body);
  endtask

  initial begin
    in_item_t it;
    int c;
    timeout_init: begin
      errors = 0; cycles = 0; n_pushed = 0; n_popped = 0; n_done = 0; n_err = 0;
    end
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    for (int i = 0; i < CONNS; i++) clear_conn(i);
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed table: method overflow, missing LF, extremes, start item.
    add_row(1, 3, 8'hFF, 1, CLS_NONE, ST_BUSY);
    for (int i = 0; i < 7; i++) add_row(0, 3, 8'h41, 1, CLS_METHOD, ST_BUSY);
    add_row(0, 3, 8'h41, 1, CLS_METHOD, ST_ERROR);
    add_row(0, 3, 8'hFF, 1, CLS_NONE, ST_ERROR);
    add_row(1, 0, 8'h00, 1, CLS_NONE, ST_BUSY);
    add_row(0, 0, 8'h00, 1, CLS_METHOD, ST_BUSY);
    add_row(0, 0, " ", 1, CLS_NONE, ST_BUSY);
    add_row(0, 0, "/", 1, CLS_PATH, ST_BUSY);
    add_row(0, 0, "?", 1, CLS_NONE, ST_BUSY);
    add_row(0, 0, "k", 1, CLS_QKEY, ST_BUSY);
    add_row(0, 0, "=", 0, CLS_NONE, ST_BUSY);
    add_row(0, 0, "=", 1, CLS_QVAL, ST_BUSY);
    add_row(0, 0, "&", 0, CLS_NONE, ST_BUSY);
    add_row(0, 0, " ", 0, CLS_NONE, ST_BUSY);
    add_row(0, 0, "V", 1, CLS_VERSION, ST_BUSY);
    add_row(0, 0, 8'h0d, 1, CLS_NONE, ST_BUSY);
    add_row(0, 0, "Z", 1, CLS_NONE, ST_ERROR);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].has_exp, directed_rows[i].exp_cls,
                directed_rows[i].exp_st);
    // Upper-case length header of 600, an empty header, and a long body over capacity.
    send_start(1);
    send_text(1, "POST /a HTTP/1.1\r\nCONTENT-LENGTH: 600\r\nX:\r\n\r\n");
    for (int i = 0; i < 600; i++) send_byte(1, 8'($urandom_range(0, 255)));
    hold_input();

    // Pause until everything in flight has come back.
    wait (expected_results.size() == 0);

    // Random part: mostly well-formed requests, some noise.
    while (n_pushed < N_ITEMS) begin
      c = $urandom_range(0, CONNS - 1);
      if ($urandom_range(0, 4) == 0) begin
        it.req_type = $urandom_range(0, 7) == 0;
        it.conn_id = 2'(c);
        it.data_byte = 8'($urandom_range(0, 255));
        send_item(it, 0, CLS_NONE, ST_BUSY);
      end else begin
        send_request(c);
      end
    end
    hold_input();

    wait (expected_results.size() == 0);
    repeat (20) @(negedge clk);
    $display("Covered %0d items and %0d results across %0d connections.", n_pushed, n_popped,
             CONNS);
    $display("Saw %0d complete-status and %0d error-status results.", n_done, n_err);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
